// ----- hdl/scpc_pkg.sv -----
// Shared types and constants for the strict convex polygon check unit.
package scpc_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  // vertex count saturates once three vertices have been seen
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_FULL = 2'd3;

  // local minima count saturates at two
  localparam logic [1:0] MIN_SAT = 2'd2;

  typedef struct packed {
    logic ok;         // strict turn in the requested orientation
    logic local_min;  // middle vertex is a lexicographic local minimum
  } turn_t;

endpackage : scpc_pkg

// ----- hdl/scpc_triple.sv -----
// Exact orientation and local minimum test for one vertex triple.
module scpc_triple #(
  parameter int unsigned COORD_WIDTH = scpc_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic                          clockwise,
  output scpc_pkg::turn_t               turn
);
  import scpc_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = PW + 1;

  logic signed [DW-1:0] d_bax, d_bay, d_cax, d_cay;
  logic signed [PW-1:0] prod_p, prod_q;
  logic signed [XW-1:0] cross_val;
  logic                 cross_neg, cross_zero;
  logic                 b_lt_a, b_lt_c;

  assign d_bax = {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
  assign d_bay = {by[COORD_WIDTH-1], by} - {ay[COORD_WIDTH-1], ay};
  assign d_cax = {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
  assign d_cay = {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};

  assign prod_p    = PW'(d_bax) * PW'(d_cay);
  assign prod_q    = PW'(d_bay) * PW'(d_cax);
  assign cross_val = {prod_p[PW-1], prod_p} - {prod_q[PW-1], prod_q};

  assign cross_neg  = cross_val[XW-1];
  assign cross_zero = (cross_val == '0);

  assign b_lt_a = (bx < ax) || ((bx == ax) && (by < ay));
  assign b_lt_c = (bx < cx) || ((bx == cx) && (by < cy));

  always_comb begin
    turn.ok        = clockwise ? cross_neg : (!cross_neg && !cross_zero);
    turn.local_min = b_lt_a && b_lt_c;
  end

endmodule : scpc_triple

// ----- hdl/scpc_poly.sv -----
// Polygon state and convexity decision for one registered vertex per cycle while advance is high.
module scpc_poly #(
  parameter int unsigned COORD_WIDTH = scpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic                          no_vertex,
  input  logic                          is_last,
  input  logic                          clockwise,
  output logic                          is_convex
);
  import scpc_pkg::*;

  logic signed [COORD_WIDTH-1:0] first_x_r, first_y_r, second_x_r, second_y_r;
  logic signed [COORD_WIDTH-1:0] older_x_r, older_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_WIDTH-1:0] first_x_nxt, first_y_nxt, second_x_nxt, second_y_nxt;
  logic signed [COORD_WIDTH-1:0] older_x_nxt, older_y_nxt, prev_x_nxt, prev_y_nxt;
  logic [1:0] seen_r, seen_nxt, minima_r, minima_nxt;
  logic       failed_r, failed_nxt;

  logic       take, a_used;
  turn_t      turn_a, turn_b, turn_c;
  logic [2:0] min_total;

  // new vertex against the two most recent
  scpc_triple #(.COORD_WIDTH(COORD_WIDTH)) u_triple_a (
    .ax(older_x_r), .ay(older_y_r), .bx(prev_x_r), .by(prev_y_r),
    .cx(vertex_x),  .cy(vertex_y),  .clockwise(clockwise), .turn(turn_a)
  );

  // wrap-around triples, on the state after this vertex
  scpc_triple #(.COORD_WIDTH(COORD_WIDTH)) u_triple_b (
    .ax(older_x_nxt), .ay(older_y_nxt), .bx(prev_x_nxt), .by(prev_y_nxt),
    .cx(first_x_r),   .cy(first_y_r),   .clockwise(clockwise), .turn(turn_b)
  );

  scpc_triple #(.COORD_WIDTH(COORD_WIDTH)) u_triple_c (
    .ax(prev_x_nxt), .ay(prev_y_nxt), .bx(first_x_r), .by(first_y_r),
    .cx(second_x_r), .cy(second_y_r), .clockwise(clockwise), .turn(turn_c)
  );

  always_comb begin
    take   = advance && !no_vertex && !failed_r;
    a_used = take && seen_r[1];

    older_x_nxt  = take ? prev_x_r : older_x_r;
    older_y_nxt  = take ? prev_y_r : older_y_r;
    prev_x_nxt   = take ? vertex_x : prev_x_r;
    prev_y_nxt   = take ? vertex_y : prev_y_r;
    first_x_nxt  = (take && seen_r == SEEN_NONE) ? vertex_x : first_x_r;
    first_y_nxt  = (take && seen_r == SEEN_NONE) ? vertex_y : first_y_r;
    second_x_nxt = (take && seen_r == SEEN_ONE) ? vertex_x : second_x_r;
    second_y_nxt = (take && seen_r == SEEN_ONE) ? vertex_y : second_y_r;

    seen_nxt   = (take && seen_r != SEEN_FULL) ? seen_r + 2'd1 : seen_r;
    failed_nxt = failed_r || (a_used && !turn_a.ok);
    minima_nxt = minima_r;
    if (a_used && turn_a.ok && turn_a.local_min && minima_r != MIN_SAT) begin
      minima_nxt = minima_r + 2'd1;
    end

    min_total = {1'b0, minima_nxt} + {2'b00, turn_b.local_min}
              + {2'b00, turn_c.local_min};

    if (failed_nxt) begin
      is_convex = 1'b0;
    end else if (seen_nxt == SEEN_NONE || seen_nxt == SEEN_ONE) begin
      is_convex = 1'b1;
    end else if (seen_nxt == SEEN_TWO) begin
      is_convex = (first_x_nxt != second_x_nxt) || (first_y_nxt != second_y_nxt);
    end else begin
      is_convex = turn_b.ok && turn_c.ok && (min_total <= 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= SEEN_NONE;
      minima_r <= '0;
      failed_r <= 1'b0;
    end else if (advance) begin
      // drop the polygon once it has been reported
      if (is_last) begin
        seen_r   <= SEEN_NONE;
        minima_r <= '0;
        failed_r <= 1'b0;
      end else begin
        seen_r   <= seen_nxt;
        minima_r <= minima_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_x_r  <= first_x_nxt;
    first_y_r  <= first_y_nxt;
    second_x_r <= second_x_nxt;
    second_y_r <= second_y_nxt;
    older_x_r  <= older_x_nxt;
    older_y_r  <= older_y_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
  end

endmodule : scpc_poly

// ----- hdl/strict_convex_polygon_check_unit.sv -----
// Top level of the strict convex polygon check unit.
// Takes one polygon vertex per transaction and, on the transaction marked
// last, returns one result saying whether the closed polygon is strictly
// convex in the orientation set by cfg_wr_data (0 counterclockwise,
// 1 clockwise). A vertex can be taken every cycle; a last vertex waits in the
// input register while an earlier result is still held, which stalls the
// input. A result becomes valid once its last vertex has passed the input
// register and then the result register.
// The rate is set by the single combinational pass of three exact
// orientation units between those registers. Write the mode only while idle.
module strict_convex_polygon_check_unit #(
  parameter int unsigned COORD_WIDTH = scpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic                          in_no_vertex,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_convex,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data
);
  import scpc_pkg::*;

  logic                          clockwise_mode_r;
  logic                          s1_valid_r;
  logic signed [COORD_WIDTH-1:0] s1_x_r, s1_y_r;
  logic                          s1_no_vertex_r, s1_last_r;
  logic                          out_valid_r, out_is_convex_r;
  logic                          out_free, s1_adv, in_take, poly_convex;

  assign out_free = !out_valid_r || out_ready;
  // hold a last vertex until the result register is free
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clockwise_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      clockwise_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r         <= in_vertex_x;
      s1_y_r         <= in_vertex_y;
      s1_no_vertex_r <= in_no_vertex;
      s1_last_r      <= in_is_last;
    end
  end

  scpc_poly #(.COORD_WIDTH(COORD_WIDTH)) u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_adv),
    .vertex_x  (s1_x_r),
    .vertex_y  (s1_y_r),
    .no_vertex (s1_no_vertex_r),
    .is_last   (s1_last_r),
    .clockwise (clockwise_mode_r),
    .is_convex (poly_convex)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_is_convex_r <= poly_convex;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_convex = out_is_convex_r;

endmodule : strict_convex_polygon_check_unit
